// ----- hw/rtl/skc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_pkg: shared types and constants of the size keyed slot cache
// Slot count, field widths, scaling constants, outcome codes and the
// request token that walks the cell chain.
// ----------------------------------------------------------------------------
package skc_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int PTS_W       = 8;
    localparam int PCT_W       = 9;
    localparam int PX_W        = 10;
    localparam int OUT_IDX_W   = 6;
    localparam int OUTCOME_W   = 2;
    localparam int SCORE_W     = 13;
    localparam int DESIGN_W    = 9;

    // round(p * 96 / 72) == floor((8p + 3) / 6), divide by 6 via reciprocal
    localparam int         NUM1_W   = 11;
    localparam int         DIV6_SH  = 16;
    localparam logic [13:0] DIV6_MUL = 14'd10923;
    localparam int         PROD1_W  = 25;

    // floor(x / 100) via reciprocal, exact for x below 199728
    localparam int          NUM2_W    = 18;
    localparam int          DIV100_SH = 24;
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    localparam int          PROD2_W   = 36;
    localparam int          QUOT2_W   = PROD2_W - DIV100_SH;

    localparam logic [NUM2_W-1:0]  ROUND_HALF = NUM2_W'(50);
    localparam logic [QUOT2_W-1:0] PX_FLOOR   = QUOT2_W'(8);
    localparam logic [QUOT2_W-1:0] PX_MAX     = QUOT2_W'(1023);

    typedef enum logic [OUTCOME_W-1:0] {
        OC_HIT     = 2'd0,
        OC_INSERT  = 2'd1,
        OC_NEAREST = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [PX_W-1:0]    px;
        logic               bold;
        logic               found;
        t_outcome           outcome;
        logic [SLOT_W-1:0]  idx;
        logic               best_vld;
        logic [SCORE_W-1:0] best_score;
        logic [SLOT_W-1:0]  best_idx;
    } t_token;

endpackage

// ----- hw/rtl/size_keyed_slot_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_keyed_slot_cache_core: font size to cache slot resolver
// Path: the request passes the skc_height register stages, the register of each
// slot cell and the output register. A new request is accepted once the last result
// has moved into the output register; one request is in flight at a time.
// Reset: synchronous, empties the table and drops any request in flight.
// ----------------------------------------------------------------------------
module size_keyed_slot_cache_core import skc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PTS_W-1:0]     i_point_size,
    input  logic                 i_want_bold,
    input  logic [PCT_W-1:0]     i_scale_pct,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_IDX_W-1:0] o_slot_index,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [PX_W-1:0]      o_pixel_height
);

    logic                 r_busy;
    logic                 r_out_vld;
    logic                 r_pend_vld;
    logic [SLOT_W-1:0]    r_out_idx;
    t_outcome             r_out_oc;
    logic [PX_W-1:0]      r_out_px;
    logic [SLOT_W-1:0]    r_pend_idx;
    t_outcome             r_pend_oc;
    logic [PX_W-1:0]      r_pend_px;

    logic                 w_acc;
    logic                 w_take;
    logic                 w_load;
    logic [SLOT_W-1:0]    w_res_idx;
    t_outcome             w_res_oc;

    logic                 w_vld [TABLE_SLOTS+1];
    t_token               w_tok [TABLE_SLOTS+1];

    assign o_ready = !r_busy;
    assign w_acc   = i_valid && o_ready;
    assign w_take  = r_out_vld && i_ready;
    assign w_load  = !r_out_vld || w_take;

    skc_height u_height (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_acc),
        .i_point_size (i_point_size),
        .i_want_bold  (i_want_bold),
        .i_scale_pct  (i_scale_pct),
        .o_vld        (w_vld[0]),
        .o_tok        (w_tok[0])
    );

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        skc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_vld   (w_vld[g]),
            .i_tok   (w_tok[g]),
            .o_vld   (w_vld[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_res_idx = w_tok[TABLE_SLOTS].found ? w_tok[TABLE_SLOTS].idx
                                                : w_tok[TABLE_SLOTS].best_idx;
    assign w_res_oc  = w_tok[TABLE_SLOTS].found ? w_tok[TABLE_SLOTS].outcome : OC_NEAREST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
            end
            if (w_load) begin
                if (r_pend_vld) begin
                    r_out_vld  <= 1'b1;
                    r_pend_vld <= 1'b0;
                    r_busy     <= 1'b0;
                end else if (w_vld[TABLE_SLOTS]) begin
                    r_out_vld <= 1'b1;
                    r_busy    <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end else if (w_vld[TABLE_SLOTS]) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend_vld) begin
                r_out_idx <= r_pend_idx;
                r_out_oc  <= r_pend_oc;
                r_out_px  <= r_pend_px;
            end else if (w_vld[TABLE_SLOTS]) begin
                r_out_idx <= w_res_idx;
                r_out_oc  <= w_res_oc;
                r_out_px  <= w_tok[TABLE_SLOTS].px;
            end
        end else if (w_vld[TABLE_SLOTS]) begin
            r_pend_idx <= w_res_idx;
            r_pend_oc  <= w_res_oc;
            r_pend_px  <= w_tok[TABLE_SLOTS].px;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_slot_index   = OUT_IDX_W'(r_out_idx);
    assign o_outcome      = r_out_oc;
    assign o_pixel_height = r_out_px;

endmodule

// ----- hw/rtl/skc_height.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_height: pixel height unit
// Four register stages: point scaling by 96/72 with rounding, percent
// scaling with rounding, clamp to 8..1023. Emits the initial search token.
// ----------------------------------------------------------------------------
module skc_height import skc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PTS_W-1:0] i_point_size,
    input  logic             i_want_bold,
    input  logic [PCT_W-1:0] i_scale_pct,
    output logic             o_vld,
    output t_token           o_tok
);

    logic [3:0]            r_vld;
    logic [PROD1_W-1:0]    r_q1;
    logic [PCT_W-1:0]      r_pct1;
    logic [3:0]            r_bold;
    logic [NUM2_W-1:0]     r_p2;
    logic [PROD2_W-1:0]    r_p3;
    logic [PX_W-1:0]       r_px;

    logic [NUM1_W-1:0]     n_num1;
    logic [DESIGN_W-1:0]   n_design;
    logic [QUOT2_W-1:0]    n_quot;

    assign n_num1   = {i_point_size, 3'b011};
    assign n_design = r_q1[DIV6_SH +: DESIGN_W];
    assign n_quot   = r_p3[DIV100_SH +: QUOT2_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bold <= {r_bold[2:0], i_want_bold};
        if (i_start) begin
            r_q1   <= PROD1_W'(n_num1) * PROD1_W'(DIV6_MUL);
            r_pct1 <= i_scale_pct;
        end
        r_p2 <= NUM2_W'(NUM2_W'(n_design) * NUM2_W'(r_pct1)) + ROUND_HALF;
        r_p3 <= PROD2_W'(r_p2) * PROD2_W'(DIV100_MUL);
        if (n_quot < PX_FLOOR) begin
            r_px <= PX_W'(PX_FLOOR);
        end else if (n_quot > PX_MAX) begin
            r_px <= PX_W'(PX_MAX);
        end else begin
            r_px <= PX_W'(n_quot);
        end
    end

    always_comb begin
        o_tok            = '0;
        o_tok.px         = r_px;
        o_tok.bold       = r_bold[3];
        o_tok.found      = 1'b0;
        o_tok.outcome    = OC_HIT;
        o_tok.best_vld   = 1'b0;
    end

    assign o_vld = r_vld[3];

endmodule

// ----- hw/rtl/skc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_cell: one slot of the cache chain
// Holds one slot, checks the passing token for an exact match, claims the
// slot when it is the first free one, and tracks the nearest slot score.
// ----------------------------------------------------------------------------
module skc_cell import skc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  logic              i_vld,
    input  t_token            i_tok,
    output logic              o_vld,
    output t_token            o_tok
);

    logic               r_filled;
    logic [PX_W-1:0]    r_height;
    logic               r_bold;
    logic               r_vld;
    t_token             r_tok;

    t_token             n_tok;
    logic               n_write;
    logic [PX_W-1:0]    w_diff;
    logic [SCORE_W-1:0] w_score;

    assign w_diff  = (r_height >= i_tok.px) ? (r_height - i_tok.px) : (i_tok.px - r_height);
    assign w_score = {(r_bold != i_tok.bold), 2'b00, w_diff};

    always_comb begin
        n_tok   = i_tok;
        n_write = 1'b0;
        if (!i_tok.found) begin
            if (r_filled) begin
                if (r_height == i_tok.px && r_bold == i_tok.bold) begin
                    n_tok.found   = 1'b1;
                    n_tok.outcome = OC_HIT;
                    n_tok.idx     = i_idx;
                end else if (!i_tok.best_vld || w_score < i_tok.best_score) begin
                    n_tok.best_vld   = 1'b1;
                    n_tok.best_score = w_score;
                    n_tok.best_idx   = i_idx;
                end
            end else begin
                n_write       = 1'b1;
                n_tok.found   = 1'b1;
                n_tok.outcome = OC_INSERT;
                n_tok.idx     = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_filled <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_vld && n_write) begin
                r_filled <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_tok <= n_tok;
        end
        if (i_vld && n_write) begin
            r_height <= i_tok.px;
            r_bold   <= i_tok.bold;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

// ----- hw/rtl/skc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_checker: port level checks of the slot cache
// Output hold under stall, result ranges, busy after a request, reset.
// ----------------------------------------------------------------------------
module skc_checker import skc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [OUT_IDX_W-1:0] o_slot_index,
    input logic [OUTCOME_W-1:0] o_outcome,
    input logic [PX_W-1:0]      o_pixel_height
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slot_index)
            && $stable(o_outcome) && $stable(o_pixel_height))
        else $error("result changed while stalled");

    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outcome == OC_HIT || o_outcome == OC_INSERT
            || o_outcome == OC_NEAREST))
        else $error("bad outcome code");

    a_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_height >= PX_W'(PX_FLOOR))
        else $error("pixel height below floor");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready after accepted request");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");

endmodule

bind size_keyed_slot_cache_core skc_checker u_skc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_slot_index   (o_slot_index),
    .o_outcome      (o_outcome),
    .o_pixel_height (o_pixel_height)
);

// ----- bench/size_keyed_slot_cache_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_keyed_slot_cache_checker: result predictor and scoreboard
// Watches the request and result channels of the slot cache. For every
// accepted request it resolves the pixel height, walks its own copy of the
// slot table and queues the expected slot, outcome and height. Every
// accepted result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module size_keyed_slot_cache_checker import skc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [PTS_W-1:0]     i_point_size,
    input  logic                 i_want_bold,
    input  logic [PCT_W-1:0]     i_scale_pct,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  logic [OUT_IDX_W-1:0] i_slot_index,
    input  logic [OUTCOME_W-1:0] i_outcome,
    input  logic [PX_W-1:0]      i_pixel_height,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_hit_cnt,
    output int                   o_insert_cnt,
    output int                   o_nearest_cnt
);

    localparam int SCREEN_DPI         = 96;
    localparam int POINT_DPI          = 72;
    localparam int MIN_HEIGHT         = 8;
    localparam int MAX_HEIGHT         = 1023;
    localparam int BOLD_MISMATCH_COST = 4096;

    typedef struct {
        logic [OUT_IDX_W-1:0] slot;
        t_outcome             outcome;
        logic [PX_W-1:0]      px;
    } t_slot_result;

    int           cached_height [TABLE_SLOTS];
    logic         cached_bold   [TABLE_SLOTS];
    int           used_slots = 0;
    t_slot_result expected_q[$];

    int fail_count  = 0;
    int pending     = 0;
    int hit_cnt     = 0;
    int insert_cnt  = 0;
    int nearest_cnt = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending;
    assign o_hit_cnt     = hit_cnt;
    assign o_insert_cnt  = insert_cnt;
    assign o_nearest_cnt = nearest_cnt;

    function automatic t_slot_result resolve_request(input logic [PTS_W-1:0] pts,
                                                     input logic bold,
                                                     input logic [PCT_W-1:0] pct);
        t_slot_result r;
        int           base_px;
        int           height;
        int           delta;
        int           score;
        int           best;
        logic         found;
        base_px = (int'(pts) * SCREEN_DPI + POINT_DPI / 2) / POINT_DPI;
        height = (base_px * int'(pct) + 50) / 100;
        if (height < MIN_HEIGHT)
            height = MIN_HEIGHT;
        if (height > MAX_HEIGHT)
            height = MAX_HEIGHT;
        r.px      = PX_W'(height);
        r.slot    = '0;
        r.outcome = OC_HIT;
        found     = 1'b0;
        for (int i = 0; i < used_slots && !found; i++) begin
            if (cached_height[i] == height && cached_bold[i] == bold) begin
                found  = 1'b1;
                r.slot = OUT_IDX_W'(i);
            end
        end
        if (!found && used_slots < TABLE_SLOTS) begin
            cached_height[used_slots] = height;
            cached_bold[used_slots]   = bold;
            r.slot                    = OUT_IDX_W'(used_slots);
            r.outcome                 = OC_INSERT;
            used_slots++;
        end else if (!found) begin
            best = 0;
            for (int i = 0; i < used_slots; i++) begin
                delta = (cached_height[i] >= height) ? cached_height[i] - height
                                                     : height - cached_height[i];
                score = delta + ((cached_bold[i] == bold) ? 0 : BOLD_MISMATCH_COST);
                if (i == 0 || score < best) begin
                    best   = score;
                    r.slot = OUT_IDX_W'(i);
                end
            end
            r.outcome = OC_NEAREST;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_slot_result want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            used_slots = 0;
            expected_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request pending: slot_index %0d outcome %0d",
                           i_slot_index, i_outcome);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, got %0d", want.slot, i_slot_index);
                        errs++;
                    end
                    if (i_outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, i_outcome);
                        errs++;
                    end
                    if (i_pixel_height !== want.px) begin
                        $error("pixel_height: expected %0d, got %0d", want.px,
                               i_pixel_height);
                        errs++;
                    end
                    case (want.outcome)
                        OC_HIT:    hit_cnt     <= hit_cnt + 1;
                        OC_INSERT: insert_cnt  <= insert_cnt + 1;
                        default:   nearest_cnt <= nearest_cnt + 1;
                    endcase
                end
            end
            if (i_req_valid && i_req_ready)
                expected_q.push_back(resolve_request(i_point_size, i_want_bold, i_scale_pct));
        end
        fail_count <= fail_count + errs;
        pending    <= expected_q.size();
    end

endmodule

// ----- bench/size_keyed_slot_cache_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_keyed_slot_cache_core_tb: testbench of the size keyed slot cache
// Drives directed corner requests, then random requests that fill the table,
// revisit cached sizes and land in the nearest-slot search once it is full.
// Both handshakes idle in random bursts; a checker predicts every result.
// ----------------------------------------------------------------------------
module size_keyed_slot_cache_core_tb;
    import skc_pkg::*;

    localparam int RANDOM_REQUESTS = 900;
    localparam int CALM_TAIL       = 150;
    localparam int DRAIN_CYCLES    = 80;

    typedef struct {
        logic [PTS_W-1:0] pts;
        logic             bold;
        logic [PCT_W-1:0] pct;
    } t_request;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic [PTS_W-1:0]     i_point_size   = '0;
    logic                 i_want_bold    = 1'b0;
    logic [PCT_W-1:0]     i_scale_pct    = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b1;
    logic [OUT_IDX_W-1:0] o_slot_index;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [PX_W-1:0]      o_pixel_height;

    logic     calm = 1'b0;
    int       sent = 0;
    int       fail_count;
    int       pending;
    int       hit_cnt;
    int       insert_cnt;
    int       nearest_cnt;
    t_request history[$];

    always #4 i_clk = ~i_clk;

    size_keyed_slot_cache_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_point_size   (i_point_size),
        .i_want_bold    (i_want_bold),
        .i_scale_pct    (i_scale_pct),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot_index   (o_slot_index),
        .o_outcome      (o_outcome),
        .o_pixel_height (o_pixel_height)
    );

    size_keyed_slot_cache_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_point_size   (i_point_size),
        .i_want_bold    (i_want_bold),
        .i_scale_pct    (i_scale_pct),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_slot_index   (o_slot_index),
        .i_outcome      (o_outcome),
        .i_pixel_height (o_pixel_height),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_hit_cnt      (hit_cnt),
        .o_insert_cnt   (insert_cnt),
        .o_nearest_cnt  (nearest_cnt)
    );

    task automatic send_request(input int pts, input int bold, input int pct);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 30) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_point_size <= PTS_W'(pts);
        i_want_bold  <= bold[0];
        i_scale_pct  <= PCT_W'(pct);
        history.push_back('{PTS_W'(pts), bold[0], PCT_W'(pct)});
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    initial begin : response_pacing
        int stall_pct;
        int burst;
        stall_pct = 15;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 299) == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                burst = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        t_request req;
        int       kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(1, 0, 50);
        send_request(255, 1, 300);
        send_request(0, 0, 100);
        send_request(10, 1, 0);
        send_request(255, 0, 511);
        send_request(255, 1, 400);
        send_request(1, 1, 511);
        send_request(170, 0, 170);
        send_request(85, 1, 341);
        send_request(12, 0, 100);
        send_request(12, 1, 100);
        send_request(255, 1, 300);
        send_request(1, 0, 50);
        send_request(0, 0, 100);
        send_request(255, 0, 511);
        send_request(12, 0, 100);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS - CALM_TAIL)
                calm <= 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                req.pts  = PTS_W'($urandom_range(0, 255));
                req.bold = 1'($urandom_range(0, 1));
                req.pct  = PCT_W'($urandom_range(0, 511));
            end else if (kind < 40) begin
                req = history[$urandom_range(0, history.size() - 1)];
                if ($urandom_range(0, 2) == 0)
                    req.bold = ~req.bold;
            end else begin
                req.pts  = PTS_W'($urandom_range(1, 255));
                req.bold = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0:       req.pct = PCT_W'(100);
                    1:       req.pct = PCT_W'(125);
                    2:       req.pct = PCT_W'(150);
                    3:       req.pct = PCT_W'(200);
                    default: req.pct = PCT_W'($urandom_range(50, 300));
                endcase
            end
            send_request(req.pts, req.bold, req.pct);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d hits, %0d inserts, %0d nearest-slot fallbacks",
                 sent, hit_cnt, insert_cnt, nearest_cnt);
        $display("Sizes, weights and scales swept incl. zero, floor and saturating heights");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
